// ===== hw/rtl/rsc_pkg.sv =====
// Shared types and constants for the reverse-Polish calculator engine.
// Used by rsc_cell, rsc_div and the top level rpn_stack_calculator.
package rsc_pkg;

  localparam int DATA_W = 32;

  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_TAKE_PREV,
    CELL_TAKE_NEXT
  } cell_op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIVW,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [4:0]               depth;
    logic [1:0]               status;
  } out_item_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_result_t;

endpackage

// ===== hw/rtl/rsc_cell.sv =====
// One stack entry of the cell chain: holds, or takes the value of the
// entry above (push) or below (pop). Depends on rsc_pkg.
module rsc_cell (
  input  logic                      clk,
  input  rsc_pkg::cell_op_t         op,
  input  logic [rsc_pkg::DATA_W-1:0] prev_value,
  input  logic [rsc_pkg::DATA_W-1:0] next_value,
  output logic [rsc_pkg::DATA_W-1:0] value_r
);

  logic [rsc_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    case (op)
      rsc_pkg::CELL_TAKE_PREV: value_nxt = prev_value;
      rsc_pkg::CELL_TAKE_NEXT: value_nxt = next_value;
      default:                 value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ===== hw/rtl/rsc_div.sv =====
// Bit-serial signed divider, truncating toward zero, one quotient bit per
// cycle. Depends on rsc_pkg. The divisor must be nonzero.
module rsc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [rsc_pkg::DATA_W-1:0] dividend,
  input  logic [rsc_pkg::DATA_W-1:0] divisor,
  output rsc_pkg::div_result_t       result
);

  localparam int W     = rsc_pkg::DATA_W;
  localparam int CNT_W = $clog2(W + 1);

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dm_r, dm_nxt;
  logic             neg_r, neg_nxt;
  logic [W:0]       shifted;
  logic [W+1:0]     trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dm_nxt   = dm_r;
    neg_nxt  = neg_r;
    shifted  = {rem_r, quo_r[W-1]};
    trial    = {1'b0, shifted} - {2'b00, dm_r};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = CNT_W'(W);
      rem_nxt = '0;
      quo_nxt = dividend[W-1] ? (W'(0) - dividend) : dividend;
      dm_nxt  = divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_nxt = dividend[W-1] ^ divisor[W-1];
    end else if (run_r) begin
      // Restoring step: keep the trial remainder when it did not borrow.
      if (!trial[W+1]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dm_r  <= dm_nxt;
    neg_r <= neg_nxt;
  end

  assign result.done     = done_r;
  assign result.quotient = neg_r ? (W'(0) - quo_r) : quo_r;

endmodule

// ===== hw/rtl/rpn_stack_calculator.sv =====
// Top level of the reverse-Polish calculator engine: control, operand
// registers and the chain of stack cells. Depends on rsc_pkg, rsc_cell, rsc_div.

// One command is taken when start is high and busy is low; busy stays high
// until its result has been shown, and the next command can be taken in the
// cycle after that. Push and the unused commands go straight to the report
// state; add, subtract, multiply and a divide by zero pass through the execute
// state first, and a divide then waits in S_DIVW on the bit-serial divider,
// which produces one quotient bit per cycle. Commands are handled one at a
// time: no command is taken while busy. Each result is on out_item for exactly one
// cycle while out_valid is high; it must be captured then, as the block
// does not wait for the receiver. The stack is a chain of STACK_DEPTH
// cells whose top entry sits in the first cell.
module rpn_stack_calculator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rsc_pkg::in_item_t  in_item,
  output logic               out_valid,
  output rsc_pkg::out_item_t out_item
);

  localparam int W  = rsc_pkg::DATA_W;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rsc_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [1:0]      status_r, status_nxt;
  logic [2:0]      cmd_r;
  logic [W-1:0]    t_r, s_r;
  logic            under_r;

  logic            accept;
  logic            push_go;
  logic            arith_wr;
  logic            div_start;
  logic            div_by_zero;
  logic [W-1:0]    r_value;
  logic [W-1:0]    load_value;
  logic [W-1:0]    cell_value [STACK_DEPTH];
  rsc_pkg::div_result_t div_res;

  assign accept      = start && !busy;
  assign div_by_zero = (t_r == '0);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsc_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_item.command) inside
            rsc_pkg::CMD_ADD, rsc_pkg::CMD_SUB,
            rsc_pkg::CMD_MUL, rsc_pkg::CMD_DIV: state_nxt = rsc_pkg::S_EXEC;
            default:                            state_nxt = rsc_pkg::S_REPORT;
          endcase
        end
      end
      rsc_pkg::S_EXEC: begin
        if (cmd_r == rsc_pkg::CMD_DIV && !div_by_zero) begin
          state_nxt = rsc_pkg::S_DIVW;
        end else begin
          state_nxt = rsc_pkg::S_REPORT;
        end
      end
      rsc_pkg::S_DIVW: begin
        if (div_res.done) begin
          state_nxt = rsc_pkg::S_REPORT;
        end
      end
      rsc_pkg::S_REPORT: state_nxt = rsc_pkg::S_IDLE;
      default:           state_nxt = rsc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    case (cmd_r)
      rsc_pkg::CMD_ADD: r_value = s_r + t_r;
      rsc_pkg::CMD_SUB: r_value = s_r - t_r;
      rsc_pkg::CMD_MUL: r_value = s_r * t_r;
      rsc_pkg::CMD_DIV: r_value = div_by_zero ? '0 : div_res.quotient;
      default:          r_value = '0;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    busy       = (state_r != rsc_pkg::S_IDLE);
    out_valid  = (state_r == rsc_pkg::S_REPORT);
    push_go    = 1'b0;
    arith_wr   = 1'b0;
    div_start  = 1'b0;
    count_nxt  = count_r;
    status_nxt = status_r;
    load_value = r_value;
    unique case (state_r)
      rsc_pkg::S_IDLE: begin
        load_value = in_item.operand_value;
        if (accept) begin
          status_nxt = rsc_pkg::ST_OK;
          if (in_item.command == rsc_pkg::CMD_PUSH) begin
            if (count_r < CW'(STACK_DEPTH)) begin
              push_go   = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              status_nxt = rsc_pkg::ST_OVER;
            end
          end
        end
      end
      rsc_pkg::S_EXEC: begin
        if (cmd_r == rsc_pkg::CMD_DIV && !div_by_zero) begin
          div_start = 1'b1;
        end else begin
          arith_wr = 1'b1;
        end
      end
      rsc_pkg::S_DIVW: arith_wr = div_res.done;
      rsc_pkg::S_REPORT: ;
      default: ;
    endcase
    // Two pops and one push: the count drops by one, or becomes one when
    // the pops ran dry.
    if (arith_wr) begin
      count_nxt = (count_r >= CW'(2)) ? (count_r - CW'(1)) : CW'(1);
      if (under_r) begin
        status_nxt = rsc_pkg::ST_UNDER;
      end else if (cmd_r == rsc_pkg::CMD_DIV && div_by_zero) begin
        status_nxt = rsc_pkg::ST_DIVZ;
      end else begin
        status_nxt = rsc_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rsc_pkg::S_IDLE;
      count_r  <= '0;
      status_r <= rsc_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
    end
  end

  // Operands are taken from the two top cells; missing entries read as zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_item.command;
      t_r     <= (count_r >= CW'(1)) ? cell_value[0] : '0;
      s_r     <= (count_r >= CW'(2)) ? cell_value[1] : '0;
      under_r <= (count_r < CW'(2));
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rsc_pkg::cell_op_t   op;
    logic [W-1:0]        prev_value;
    logic [W-1:0]        next_value;

    if (i == 0) begin : g_top
      assign prev_value = load_value;
      assign op = (push_go || arith_wr) ? rsc_pkg::CELL_TAKE_PREV : rsc_pkg::CELL_HOLD;
    end else begin : g_body
      assign prev_value = cell_value[i-1];
      assign op = push_go  ? rsc_pkg::CELL_TAKE_PREV :
                  arith_wr ? rsc_pkg::CELL_TAKE_NEXT : rsc_pkg::CELL_HOLD;
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_value = cell_value[i];
    end else begin : g_inner
      assign next_value = cell_value[i+1];
    end

    rsc_cell u_cell (
      .clk        (clk),
      .op         (op),
      .prev_value (prev_value),
      .next_value (next_value),
      .value_r    (cell_value[i])
    );
  end

  rsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (s_r),
    .divisor  (t_r),
    .result   (div_res)
  );

  assign out_item.top_value = (count_r == '0) ? '0 : cell_value[0];
  assign out_item.depth     = 5'(count_r);
  assign out_item.status    = status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push_go |=> (count_r == $past(count_r) + CW'(1)) && out_valid)
    else $error("push did not grow the stack");

  a_div_report: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rsc_pkg::S_DIVW && div_res.done) |=> out_valid)
    else $error("divide result not reported");

  a_no_double_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_go && arith_wr))
    else $error("push and arithmetic write in one cycle");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for rpn_stack_calculator: queued commands, a stack
// predictor, and a result checker with a no-progress watchdog.
// Depends on rsc_pkg and the rpn_stack_calculator RTL.
module tb;
  import rsc_pkg::*;

  localparam int STACK_DEPTH = 16;
  localparam int RANDOM_ITEMS = 1250;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [2:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0] CMD_SPARE_MID = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI  = 3'd7;

  localparam logic [31:0] INT_MIN = 32'h8000_0000;
  localparam logic [31:0] INT_MAX = 32'h7fff_ffff;

  typedef struct {
    in_item_t item;
    int       gap;
    bit       drain;
  } pending_cmd_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  pending_cmd_t cmd_queue[$];
  out_item_t    stack_results[$];

  // Predicted stack contents and fill level.
  logic [31:0] calc_stack[STACK_DEPTH];
  int          calc_count = 0;

  // Fill level assumed by the stimulus generator, used only to shape sequences.
  int plan_depth = 0;
  int useful_total = 0;
  int item_total = 0;
  bit no_idle = 1'b0;

  int taken_total = 0;
  int driven_total = 0;
  int idle_left = -1;
  int quiet_cycles = 0;
  int fail_count = 0;

  rpn_stack_calculator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [31:0] stack_pop(output logic was_empty);
    logic [31:0] value;
    if (calc_count > 0) begin
      calc_count--;
      value = calc_stack[calc_count];
      was_empty = 1'b0;
    end else begin
      value = '0;
      was_empty = 1'b1;
    end
    return value;
  endfunction

  function automatic out_item_t rpn_predict(in_item_t cmd_item);
    logic [31:0] lhs, rhs, res, nmag, dmag, quot;
    logic        empty_rhs, empty_lhs, div_zero;
    out_item_t   r;
    r.status = ST_OK;
    div_zero = 1'b0;
    if (cmd_item.command == CMD_PUSH) begin
      if (calc_count < STACK_DEPTH) begin
        calc_stack[calc_count] = cmd_item.operand_value;
        calc_count++;
      end else begin
        r.status = ST_OVER;
      end
    end else if (cmd_item.command <= CMD_DIV) begin
      rhs = stack_pop(empty_rhs);
      lhs = stack_pop(empty_lhs);
      case (cmd_item.command)
        CMD_ADD: res = lhs + rhs;
        CMD_SUB: res = lhs - rhs;
        CMD_MUL: res = lhs * rhs;
        default: begin
          if (rhs == '0) begin
            res = '0;
            div_zero = 1'b1;
          end else begin
            // Divide magnitudes, then restore the sign: truncates toward zero
            // and lets the most negative value over -1 wrap to itself.
            nmag = lhs[31] ? -lhs : lhs;
            dmag = rhs[31] ? -rhs : rhs;
            quot = nmag / dmag;
            res = (lhs[31] ^ rhs[31]) ? -quot : quot;
          end
        end
      endcase
      calc_stack[calc_count] = res;
      calc_count++;
      if (empty_rhs || empty_lhs) r.status = ST_UNDER;
      else if (div_zero) r.status = ST_DIVZ;
    end
    r.top_value = (calc_count == 0) ? '0 : calc_stack[calc_count - 1];
    r.depth = 5'(calc_count);
    return r;
  endfunction

  function automatic logic [31:0] draw_operand();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick <= 3) return $urandom;
    if (pick <= 6) return 32'($urandom_range(0, 16)) - 32'd8;
    if (pick == 7) return INT_MIN;
    if (pick == 8) return INT_MAX;
    return 32'($urandom_range(0, 2)) - 32'd1;
  endfunction

  task automatic add_item(logic [2:0] cmd, logic [31:0] value, bit drain = 1'b0);
    pending_cmd_t p;
    int           roll;
    p.item.command = cmd;
    p.item.operand_value = value;
    p.drain = drain;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 55) p.gap = 0;
    else if (roll < 85) p.gap = $urandom_range(1, 3);
    else if (roll < 97) p.gap = $urandom_range(4, 15);
    else p.gap = $urandom_range(30, 80);
    cmd_queue.push_back(p);
    item_total++;
    if (cmd == CMD_PUSH) begin
      useful_total++;
      if (plan_depth < STACK_DEPTH) plan_depth++;
    end else if (cmd <= CMD_DIV) begin
      useful_total++;
      plan_depth = (plan_depth >= 2) ? plan_depth - 1 : 1;
    end
  endtask

  task automatic add_op();
    add_item(3'($urandom_range(CMD_ADD, CMD_DIV)), $urandom);
  endtask

  // Driver: presents queued items at the falling edge after their idle gap.
  always @(negedge clk) begin : drive_proc
    logic go;
    go = start;
    if (start && taken_total != driven_total) begin
      driven_total++;
      go = 1'b0;
      idle_left = -1;
    end
    if (!go && rst_n && cmd_queue.size() > 0) begin
      if (idle_left < 0) idle_left = cmd_queue[0].gap;
      if (idle_left > 0) begin
        idle_left--;
      end else if (!cmd_queue[0].drain || stack_results.size() == 0) begin
        in_item <= cmd_queue[0].item;
        go = 1'b1;
        cmd_queue.pop_front();
        idle_left = -1;
      end
    end
    start <= go;
  end

  // Monitor: checks each result strobe and predicts every accepted item.
  always @(posedge clk) begin : check_proc
    out_item_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (stack_results.size() == 0) begin
          $error("result with no item outstanding: top_value %0d depth %0d status %0d",
                 out_item.top_value, out_item.depth, out_item.status);
          fail_count++;
        end else begin
          want = stack_results.pop_front();
          if (out_item.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, out_item.top_value);
            fail_count++;
          end
          if (out_item.depth !== want.depth) begin
            $error("depth: expected %0d, got %0d", want.depth, out_item.depth);
            fail_count++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        taken_total++;
        stack_results.push_back(rpn_predict(in_item));
      end
      if (out_valid || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int burst;

    // Directed part: spare commands, pops from an empty stack, the most
    // negative value over -1, divide by zero, a full stack and wrapping.
    add_item(CMD_SPARE_LO, INT_MAX);
    add_item(CMD_SPARE_MID, INT_MIN);
    add_item(CMD_SPARE_HI, '1);
    add_item(CMD_ADD, '0);
    add_item(CMD_DIV, INT_MAX);
    add_item(CMD_PUSH, INT_MIN);
    add_item(CMD_PUSH, '1);
    add_item(CMD_DIV, '0);
    add_item(CMD_PUSH, '0);
    add_item(CMD_DIV, '1);
    while (plan_depth < STACK_DEPTH) add_item(CMD_PUSH, INT_MAX);
    add_item(CMD_PUSH, INT_MIN);
    add_item(CMD_MUL, '0, 1'b1);
    add_item(CMD_SUB, INT_MAX);
    add_item(CMD_ADD, INT_MIN);

    // Random part: mostly well-formed push/operate sequences, with bursts
    // that fill the stack past its limit or drain it down to underflow.
    while (useful_total < item_total + RANDOM_ITEMS - cmd_queue.size() &&
           useful_total < 30 + RANDOM_ITEMS) begin
      if (item_total % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(0, 99);
      if (item_total % 250 == 0) begin
        add_item(CMD_PUSH, draw_operand(), 1'b1);
      end else if (burst < 2) begin
        while (plan_depth < STACK_DEPTH) add_item(CMD_PUSH, draw_operand());
        repeat ($urandom_range(1, 3)) add_item(CMD_PUSH, draw_operand());
      end else if (burst < 4) begin
        while (plan_depth > 1) add_op();
        repeat ($urandom_range(1, 3)) add_op();
      end else if (burst < 8) begin
        add_item(3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)), $urandom);
      end else if ((plan_depth < 2 && burst < 80) ||
                   (plan_depth >= 14 && burst < 35) ||
                   (plan_depth >= 2 && plan_depth < 14 && burst < 54)) begin
        add_item(CMD_PUSH, draw_operand());
      end else begin
        add_op();
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (taken_total < item_total) @(posedge clk);
    while (stack_results.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
